// ===== rtl/pfa_pkg.sv =====
// Package with the shared codes, states and control structs of the page frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package pfa_pkg;

  localparam logic [1:0] REQ_INIT  = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;
  localparam logic [1:0] REQ_OWNER = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_FREE   = 2'd1;
  localparam logic [1:0] STAT_RANGE     = 2'd2;
  localparam logic [1:0] STAT_NOT_ALLOC = 2'd3;

  localparam logic [9:0] FIRST_FRAME_RESET = 10'd256;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_RD,
    S_A1,
    S_A2,
    S_A3,
    S_CHK,
    S_R1,
    S_R2,
    S_R3,
    S_DONE
  } pfa_state_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_BUILD,
    OP_TAKE,
    OP_READ,
    OP_ALLOC1,
    OP_ALLOC2,
    OP_ALLOC3,
    OP_NOTALLOC,
    OP_ADVANCE,
    OP_REL1,
    OP_REL2,
    OP_REL3,
    OP_RESULT
  } pfa_op_e;

  typedef struct packed {
    pfa_op_e op;
  } pfa_cmd_t;

  typedef struct packed {
    logic free_empty;
    logic used_empty;
    logic range_bad;
    logic tag_valid;
    logic tag_own;
    logic nx_null;
    logic sweep_last;
    logic out_free;
  } pfa_sts_t;

endpackage
`default_nettype wire

// ===== rtl/pfa_if.sv =====
// Channel interfaces of the page frame allocator: request, result and configuration.
`timescale 1ns / 1ps
`default_nettype none
interface pfa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  owner;
  logic [21:0] phys_addr;
  modport source (output valid, output req_type, output owner, output phys_addr, input ready);
  modport sink (input valid, input req_type, input owner, input phys_addr, output ready);
endinterface

interface pfa_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [21:0] frame_addr;
  logic [10:0] freed_count;
  modport source (output valid, output status, output frame_addr, output freed_count,
                  input ready);
  modport sink (input valid, input status, input frame_addr, input freed_count,
                output ready);
endinterface

interface pfa_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/page_frame_allocator_unit.sv =====
// Top level of the page frame allocator: controller, datapath and channel hookup.
`timescale 1ns / 1ps
`default_nettype none
// Allocator of NUM_FRAMES physical 4 KiB frames kept on a free list and an allocated
// list, both doubly linked through per-frame link memories, with an owner tag per frame.
// After reset a clearing pass over all frames runs before the first item is taken.
// Items are handled one at a time by a state machine that steps through one-port
// link memory accesses: an allocate reads the head frame's links, then runs the
// allocation steps; a free checks the range, reads and checks the frame's tag, then
// runs the release steps, and stops after the check on a frame that is not allocated;
// an init sweeps all frames; a free-by-owner walks the allocated list, releasing
// each frame of that owner. The final step waits while an earlier result is held.
// A result waits in an output register, so the next item is taken while it is pending.
module page_frame_allocator_unit #(
  parameter int NUM_FRAMES = 1024,
  parameter int NUM_OWNERS = 16
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  pfa_req_if.sink   req_i,
  pfa_res_if.source res_o,
  pfa_cfg_if.sink   cfg_i
);
  import pfa_pkg::*;

  pfa_cmd_t cmd;
  pfa_sts_t sts;

  assign cfg_i.ready = 1'b1;

  pfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pfa_dp #(
    .NUM_FRAMES (NUM_FRAMES),
    .NUM_OWNERS (NUM_OWNERS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_i.req_type),
    .owner_i       (req_i.owner),
    .phys_addr_i   (req_i.phys_addr),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .res_valid_o   (res_o.valid),
    .res_ready_i   (res_o.ready),
    .status_o      (res_o.status),
    .frame_addr_o  (res_o.frame_addr),
    .freed_count_o (res_o.freed_count)
  );

  // Once an item is taken the block is not ready again in the following cycle.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request ready right after an accepted item");

  // Released frames are only reported on a successful request.
  a_count_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.freed_count != 11'd0) |-> (res_o.status == STAT_OK))
    else $error("freed count with an error status");

  // An allocation result never also reports released frames.
  a_addr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.frame_addr != 22'd0) |-> (res_o.freed_count == 11'd0))
    else $error("frame address and freed count both set");

endmodule
`default_nettype wire

// ===== rtl/pfa_ctrl.sv =====
// Controller state machine that sequences the link memory steps of each request.
`timescale 1ns / 1ps
`default_nettype none
module pfa_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  input  wire logic [1:0]      req_type_i,
  output logic                 req_ready_o,
  input  wire pfa_pkg::pfa_sts_t sts_i,
  output pfa_pkg::pfa_cmd_t    cmd_o
);
  import pfa_pkg::*;

  pfa_state_e state_q, state_d;
  logic [1:0] req_q, req_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      req_q   <= REQ_INIT;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
    end
  end

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    unique case (state_q)
      S_CLEAR: if (sts_i.sweep_last) state_d = S_IDLE;
      S_IDLE: begin
        if (req_valid_i) begin
          req_d = req_type_i;
          unique case (req_type_i)
            REQ_INIT:  state_d = S_INIT;
            REQ_ALLOC: state_d = sts_i.free_empty ? S_DONE : S_RD;
            REQ_FREE:  state_d = sts_i.range_bad ? S_DONE : S_RD;
            default:   state_d = sts_i.used_empty ? S_DONE : S_RD;
          endcase
        end
      end
      S_INIT: if (sts_i.sweep_last) state_d = S_DONE;
      S_RD:   state_d = (req_q == REQ_ALLOC) ? S_A1 : S_CHK;
      S_A1:   state_d = S_A2;
      S_A2:   state_d = S_A3;
      S_A3:   state_d = S_DONE;
      S_CHK: begin
        if (req_q == REQ_FREE) begin
          state_d = sts_i.tag_valid ? S_R1 : S_DONE;
        end else if (sts_i.tag_own) begin
          state_d = S_R1;
        end else begin
          state_d = sts_i.nx_null ? S_DONE : S_RD;
        end
      end
      S_R1: state_d = S_R2;
      S_R2: state_d = S_R3;
      S_R3: state_d = (req_q == REQ_FREE || sts_i.nx_null) ? S_DONE : S_RD;
      S_DONE: if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op    = OP_NOP;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: cmd_o.op = OP_CLEAR;
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) cmd_o.op = OP_TAKE;
      end
      S_INIT: cmd_o.op = OP_BUILD;
      S_RD:   cmd_o.op = OP_READ;
      S_A1:   cmd_o.op = OP_ALLOC1;
      S_A2:   cmd_o.op = OP_ALLOC2;
      S_A3:   cmd_o.op = OP_ALLOC3;
      S_CHK: begin
        if (req_q == REQ_FREE) begin
          if (!sts_i.tag_valid) cmd_o.op = OP_NOTALLOC;
        end else if (!sts_i.tag_own) begin
          cmd_o.op = OP_ADVANCE;
        end
      end
      S_R1: cmd_o.op = OP_REL1;
      S_R2: cmd_o.op = OP_REL2;
      S_R3: cmd_o.op = OP_REL3;
      S_DONE: if (sts_i.out_free) cmd_o.op = OP_RESULT;
      default: cmd_o.op = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/pfa_dp.sv =====
// Datapath with the link and owner memories, list heads and the result register.
`timescale 1ns / 1ps
`default_nettype none
module pfa_dp #(
  parameter int NUM_FRAMES = 1024,
  parameter int NUM_OWNERS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pfa_pkg::pfa_cmd_t cmd_i,
  output pfa_pkg::pfa_sts_t      sts_o,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [3:0]        owner_i,
  input  wire logic [21:0]       phys_addr_i,
  input  wire logic              cfg_valid_i,
  input  wire logic [9:0]        cfg_data_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output logic [1:0]             status_o,
  output logic [21:0]            frame_addr_o,
  output logic [10:0]            freed_count_o
);
  import pfa_pkg::*;

  localparam int FW   = $clog2(NUM_FRAMES);
  localparam int LW   = $clog2(NUM_FRAMES + 1);
  localparam int TW   = $clog2(NUM_OWNERS + 1);
  localparam int CMPW = ((FW > 10) ? FW : 10) + 2;
  localparam logic [LW-1:0] NIL    = LW'(NUM_FRAMES);
  localparam logic [TW-1:0] NO_OWN = TW'(NUM_OWNERS);

  // Owner reduced modulo the owner count by repeated subtraction of a 4-bit value.
  function automatic logic [TW-1:0] owner_mod(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    for (int k = 0; k < 8; k++) begin
      if (int'(r) >= NUM_OWNERS) r = r - 4'(NUM_OWNERS);
    end
    return TW'(r);
  endfunction

  logic [TW-1:0] tag_mem [NUM_FRAMES];
  logic [LW-1:0] next_mem [NUM_FRAMES];
  logic [LW-1:0] prev_mem [NUM_FRAMES];

  logic [9:0]    ff_q;
  logic [LW-1:0] free_head_q, used_head_q, cur_q, count_q;
  logic [FW-1:0] idx_q;
  logic [TW-1:0] own_q;
  logic [LW-1:0] nx_r, pv_r;
  logic [TW-1:0] tag_r;
  logic [1:0]    stat_q;
  logic [21:0]   addr_q;
  logic          out_valid_q;
  logic [1:0]    res_stat_q;
  logic [21:0]   res_addr_q;
  logic [10:0]   res_count_q;

  logic [9:0]    frame_in;
  logic          nx_valid, pv_valid, fh_valid, uh_valid, in_range;
  logic [LW-1:0] sweep_next, sweep_prev;
  logic          nm_we, pm_we, tm_we;
  logic [FW-1:0] nm_wa, pm_wa, tm_wa;
  logic [LW-1:0] nm_wd, pm_wd;
  logic [TW-1:0] tm_wd;

  assign frame_in = phys_addr_i[21:12];
  assign nx_valid = (nx_r != NIL);
  assign pv_valid = (pv_r != NIL);
  assign fh_valid = (free_head_q != NIL);
  assign uh_valid = (used_head_q != NIL);
  assign in_range = (CMPW'(idx_q) >= CMPW'(ff_q));

  always_comb begin
    sweep_next = NIL;
    sweep_prev = NIL;
    if (cmd_i.op == OP_BUILD && in_range) begin
      if ((CMPW'(idx_q) + CMPW'(1)) < CMPW'(NUM_FRAMES)) sweep_next = LW'(idx_q) + LW'(1);
      if (CMPW'(idx_q) != CMPW'(ff_q)) sweep_prev = LW'(idx_q) - LW'(1);
    end
  end

  always_comb begin
    sts_o.free_empty = !fh_valid;
    sts_o.used_empty = !uh_valid;
    sts_o.range_bad  = (frame_in < ff_q) || (CMPW'(frame_in) >= CMPW'(NUM_FRAMES));
    sts_o.tag_valid  = (tag_r != NO_OWN);
    sts_o.tag_own    = (tag_r == own_q);
    sts_o.nx_null    = !nx_valid;
    sts_o.sweep_last = (CMPW'(idx_q) == CMPW'(NUM_FRAMES - 1));
    sts_o.out_free   = !out_valid_q || res_ready_i;
  end

  // Write port selection for the three memories.
  always_comb begin
    nm_we = 1'b0; nm_wa = cur_q[FW-1:0]; nm_wd = NIL;
    pm_we = 1'b0; pm_wa = cur_q[FW-1:0]; pm_wd = NIL;
    tm_we = 1'b0; tm_wa = cur_q[FW-1:0]; tm_wd = NO_OWN;
    case (cmd_i.op)
      OP_CLEAR, OP_BUILD: begin
        nm_we = 1'b1; nm_wa = idx_q; nm_wd = sweep_next;
        pm_we = 1'b1; pm_wa = idx_q; pm_wd = sweep_prev;
        tm_we = 1'b1; tm_wa = idx_q;
      end
      OP_ALLOC1: begin
        nm_we = 1'b1; nm_wd = used_head_q;
        pm_we = 1'b1;
        tm_we = 1'b1; tm_wd = own_q;
      end
      OP_ALLOC2: begin
        pm_we = nx_valid; pm_wa = nx_r[FW-1:0];
      end
      OP_ALLOC3: begin
        pm_we = uh_valid; pm_wa = used_head_q[FW-1:0]; pm_wd = cur_q;
      end
      OP_REL1: begin
        nm_we = pv_valid; nm_wa = pv_r[FW-1:0]; nm_wd = nx_r;
        pm_we = nx_valid; pm_wa = nx_r[FW-1:0]; pm_wd = pv_r;
        tm_we = 1'b1;
      end
      OP_REL2: begin
        nm_we = 1'b1; nm_wd = free_head_q;
        pm_we = 1'b1;
      end
      OP_REL3: begin
        pm_we = fh_valid; pm_wa = free_head_q[FW-1:0]; pm_wd = cur_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (nm_we) next_mem[nm_wa] <= nm_wd;
    if (pm_we) prev_mem[pm_wa] <= pm_wd;
    if (tm_we) tag_mem[tm_wa] <= tm_wd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_READ) begin
      nx_r  <= next_mem[cur_q[FW-1:0]];
      pv_r  <= prev_mem[cur_q[FW-1:0]];
      tag_r <= tag_mem[cur_q[FW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_q        <= FIRST_FRAME_RESET;
      free_head_q <= NIL;
      used_head_q <= NIL;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) ff_q <= cfg_data_i;
      if (cmd_i.op == OP_RESULT) out_valid_q <= 1'b1;
      else if (out_valid_q && res_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_CLEAR, OP_BUILD: idx_q <= idx_q + FW'(1);
        OP_TAKE: begin
          idx_q <= '0;
          if (req_type_i == REQ_INIT) begin
            free_head_q <= (CMPW'(ff_q) < CMPW'(NUM_FRAMES)) ? LW'(ff_q) : NIL;
            used_head_q <= NIL;
          end
        end
        OP_ALLOC1: free_head_q <= nx_r;
        OP_ALLOC3: used_head_q <= cur_q;
        OP_REL1:   if (used_head_q == cur_q) used_head_q <= nx_r;
        OP_REL3:   free_head_q <= cur_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_TAKE: begin
        own_q   <= owner_mod(owner_i);
        addr_q  <= '0;
        count_q <= '0;
        stat_q  <= STAT_OK;
        case (req_type_i)
          REQ_ALLOC: begin
            cur_q <= free_head_q;
            if (!fh_valid) stat_q <= STAT_NO_FREE;
          end
          REQ_FREE: begin
            cur_q <= LW'(frame_in);
            if (sts_o.range_bad) stat_q <= STAT_RANGE;
          end
          default: cur_q <= used_head_q;
        endcase
      end
      OP_ALLOC3:   addr_q <= 22'({cur_q[FW-1:0], 12'b0});
      OP_NOTALLOC: stat_q <= STAT_NOT_ALLOC;
      OP_ADVANCE:  cur_q <= nx_r;
      OP_REL3: begin
        cur_q   <= nx_r;
        count_q <= count_q + LW'(1);
      end
      OP_RESULT: begin
        res_stat_q  <= stat_q;
        res_addr_q  <= addr_q;
        res_count_q <= 11'(count_q);
      end
      default: ;
    endcase
  end

  assign res_valid_o   = out_valid_q;
  assign status_o      = res_stat_q;
  assign frame_addr_o  = res_addr_q;
  assign freed_count_o = res_count_q;

endmodule
`default_nettype wire

// ===== bench/tb_page_frame_allocator_unit.sv =====
// Self-checking testbench of the page frame allocator with a list-tracking scoreboard.
`timescale 1ns / 1ps
module tb_page_frame_allocator_unit;
  import pfa_pkg::*;

  localparam int NUM_FRAMES = 1024;
  localparam int NUM_OWNERS = 16;
  localparam logic [10:0] NULL_LINK = 11'd1024;
  localparam logic [4:0] NO_OWNER = 5'd16;

  typedef struct packed {
    logic [1:0]  status;
    logic [21:0] frame_addr;
    logic [10:0] freed_count;
  } alloc_result_t;

  class frame_scoreboard;
    logic [10:0] next_q [NUM_FRAMES];
    logic [10:0] prev_q [NUM_FRAMES];
    logic [4:0] tag_q [NUM_FRAMES];
    logic [10:0] free_head;
    logic [10:0] used_head;
    logic [9:0] first_frame;
    int used_count;
    alloc_result_t expected_q[$];
    int errors;

    function new();
      first_frame = FIRST_FRAME_RESET;
      errors = 0;
      clear_lists();
    endfunction

    function void clear_lists();
      for (int i = 0; i < NUM_FRAMES; i++) begin
        next_q[i] = NULL_LINK;
        prev_q[i] = NULL_LINK;
        tag_q[i] = NO_OWNER;
      end
      free_head = NULL_LINK;
      used_head = NULL_LINK;
      used_count = 0;
    endfunction

    function void build_free_list();
      clear_lists();
      for (int i = first_frame; i < NUM_FRAMES; i++) begin
        prev_q[i] = (i == first_frame) ? NULL_LINK : 11'(i - 1);
        next_q[i] = (i + 1 < NUM_FRAMES) ? 11'(i + 1) : NULL_LINK;
      end
      free_head = 11'(first_frame);
    endfunction

    // Unlinks an allocated frame and pushes it on the free head.
    function void release_frame(logic [10:0] f);
      logic [10:0] nx;
      logic [10:0] pv;
      nx = next_q[f];
      pv = prev_q[f];
      tag_q[f] = NO_OWNER;
      if (pv != NULL_LINK) next_q[pv] = nx;
      if (nx != NULL_LINK) prev_q[nx] = pv;
      if (used_head == f) used_head = nx;
      prev_q[f] = NULL_LINK;
      next_q[f] = free_head;
      if (free_head != NULL_LINK) prev_q[free_head] = f;
      free_head = f;
      used_count--;
    endfunction

    function void note_request(logic [1:0] req, logic [3:0] own, logic [21:0] addr);
      alloc_result_t r;
      logic [10:0] f;
      logic [10:0] cur;
      logic [10:0] nx;
      r = '0;
      f = {1'b0, addr[21:12]};
      case (req)
        REQ_INIT: build_free_list();
        REQ_ALLOC: begin
          if (free_head == NULL_LINK) begin
            r.status = STAT_NO_FREE;
          end else begin
            cur = free_head;
            free_head = next_q[cur];
            if (free_head != NULL_LINK) prev_q[free_head] = NULL_LINK;
            next_q[cur] = used_head;
            prev_q[cur] = NULL_LINK;
            if (used_head != NULL_LINK) prev_q[used_head] = cur;
            used_head = cur;
            tag_q[cur] = {1'b0, own};
            used_count++;
            r.frame_addr = {cur[9:0], 12'd0};
          end
        end
        REQ_FREE: begin
          if (f < first_frame) r.status = STAT_RANGE;
          else if (tag_q[f] == NO_OWNER) r.status = STAT_NOT_ALLOC;
          else begin
            release_frame(f);
            r.freed_count = 11'd1;
          end
        end
        default: begin
          cur = used_head;
          while (cur != NULL_LINK) begin
            nx = next_q[cur];
            if (tag_q[cur] == {1'b0, own}) begin
              release_frame(cur);
              r.freed_count++;
            end
            cur = nx;
          end
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: status %0d addr %h count %0d",
                 $realtime, got.status, got.frame_addr, got.freed_count);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, exp_r.status, got.status);
        errors++;
      end
      if (got.frame_addr !== exp_r.frame_addr) begin
        $display("%0t: frame_addr expected %h actual %h", $realtime, exp_r.frame_addr,
                 got.frame_addr);
        errors++;
      end
      if (got.freed_count !== exp_r.freed_count) begin
        $display("%0t: freed_count expected %0d actual %0d", $realtime, exp_r.freed_count,
                 got.freed_count);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Returns a random allocated frame, or the null link when none is allocated.
    function logic [10:0] pick_used();
      logic [10:0] cur;
      int k;
      if (used_count == 0) return NULL_LINK;
      k = $urandom_range(0, used_count - 1);
      cur = used_head;
      for (int i = 0; i < k; i++) cur = next_q[cur];
      return cur;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit quiet = 1'b0;
  frame_scoreboard sb;

  pfa_req_if req_if ();
  pfa_res_if res_if ();
  pfa_cfg_if cfg_if ();

  page_frame_allocator_unit #(
    .NUM_FRAMES(NUM_FRAMES),
    .NUM_OWNERS(NUM_OWNERS)
  ) uut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .req_i(req_if),
    .res_o(res_if),
    .cfg_i(cfg_if)
  );

  always #5 clk = ~clk;

  initial begin
    req_if.valid = 1'b0;
    req_if.req_type = REQ_INIT;
    req_if.owner = '0;
    req_if.phys_addr = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
  end

  task automatic send_request(logic [1:0] req, logic [3:0] own, logic [21:0] addr);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.req_type <= req;
    req_if.owner <= own;
    req_if.phys_addr <= addr;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(req, own, addr);
  endtask

  // Drains all results, lets the block settle, then writes the register.
  task automatic write_first_frame(logic [9:0] value);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.first_frame = value;
  endtask

  task automatic send_random_request();
    int pick;
    logic [10:0] f;
    logic [21:0] addr;
    pick = $urandom_range(0, 99);
    addr = 22'($urandom);
    if (pick < 2) begin
      send_request(REQ_INIT, 4'($urandom), addr);
    end else if (pick < 47) begin
      send_request(REQ_ALLOC, 4'($urandom), addr);
    end else if (pick < 90) begin
      f = sb.pick_used();
      if (f != NULL_LINK && $urandom_range(0, 9) < 7) addr[21:12] = f[9:0];
      send_request(REQ_FREE, 4'($urandom), addr);
    end else begin
      send_request(REQ_OWNER, 4'($urandom), addr);
    end
  endtask

  always begin
    int stall;
    alloc_result_t got;
    @(posedge clk);
    while (1) begin
      stall = quiet ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      got.status = res_if.status;
      got.frame_addr = res_if.frame_addr;
      got.freed_count = res_if.freed_count;
      sb.check_result(got);
    end
  end

  initial begin
    #60ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [9:0] settings [7];
    sb = new();
    settings = '{10'd0, 10'd1023, 10'd1, 10'd1000, 10'd256, 10'd512, 10'd0};
    settings[6] = 10'($urandom_range(1, 1023));
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Requests before any init, then basic traffic at the reset register value.
    send_request(REQ_ALLOC, 4'hF, 22'd0);
    send_request(REQ_FREE, 4'h0, 22'h3FFFFF);
    send_request(REQ_FREE, 4'h0, 22'h0FFFFF);
    send_request(REQ_OWNER, 4'h3, 22'd0);
    send_request(REQ_INIT, 4'h0, 22'h3FFFFF);
    send_request(REQ_ALLOC, 4'h0, 22'd0);
    send_request(REQ_ALLOC, 4'hF, 22'd0);
    send_request(REQ_ALLOC, 4'h5, 22'h3FFFFF);
    send_request(REQ_ALLOC, 4'hF, 22'd0);
    send_request(REQ_FREE, 4'h0, {10'd257, 12'hFFF});
    send_request(REQ_FREE, 4'h0, {10'd257, 12'h000});
    send_request(REQ_FREE, 4'h0, {10'd255, 12'hABC});
    send_request(REQ_FREE, 4'h0, 22'd0);
    send_request(REQ_FREE, 4'h0, 22'h3FFFFF);
    send_request(REQ_OWNER, 4'hF, 22'd0);
    send_request(REQ_OWNER, 4'h7, 22'd0);
    send_request(REQ_OWNER, 4'h0, 22'h3FFFFF);

    foreach (settings[p]) begin
      write_first_frame(settings[p]);
      quiet = (p % 3 == 2);
      send_request(REQ_INIT, 4'($urandom), 22'($urandom));
      for (int i = 0; i < 260; i++) send_random_request();
      // Changing the register without an init only moves the range check.
      if (p == 3) begin
        write_first_frame(10'd1020);
        for (int i = 0; i < 20; i++) send_random_request();
      end
    end
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/pfa_pkg.sv
rtl/pfa_if.sv
rtl/pfa_ctrl.sv
rtl/pfa_dp.sv
rtl/page_frame_allocator_unit.sv
bench/tb_page_frame_allocator_unit.sv
